[rtl/uee_pkg.sv]
// Shared types and constants for the UTF-8 escape expander.
`timescale 1ns / 1ps

package uee_pkg;

	// Configuration register indexes.
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_EOL_CARE = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [15:0] CAPACITY_RESET = 16'd256;
	localparam logic        EOL_CARE_RESET = 1'b0;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Most byte words that one input word can cause.
	localparam int MAX_BYTES = 5;

	// Command handed from the front to the back: bytes to emit, then an
	// optional closing word.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                num;
		logic                      last;
	} cmd_t;

endpackage

[rtl/utf8_escape_expander.sv]
// A word accepted at the input is written into the command queue, and its first result
// word is then loaded from the queue head into the registered output.
// Throughput: one input word a cycle while the queue is not full and each causes one
// result word; the back part sends one result word a cycle while out_ready is high, and
// the queue lets the front run ahead while the back sends an escape flush of up to six words.
// Reset: capacity 256, eol_care 0, parser and length state cleared, queue empty.
`timescale 1ns / 1ps

module utf8_escape_expander #(
	parameter int QUEUE_DEPTH = uee_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_end,
	output logic        overflow,
	output logic [15:0] out_length
);

	logic [15:0]   capacity_q;
	logic          eol_care_q;
	logic          q_full;
	logic          push;
	logic          pop;
	logic          head_valid;
	uee_pkg::cmd_t push_cmd;
	uee_pkg::cmd_t head_cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= uee_pkg::CAPACITY_RESET;
			eol_care_q <= uee_pkg::EOL_CARE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uee_pkg::REG_CAPACITY: capacity_q <= cfg_data;
				uee_pkg::REG_EOL_CARE: eol_care_q <= cfg_data[0];
			endcase
		end
	end

	uee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.eol_care (eol_care_q),
		.q_full   (q_full),
		.push     (push),
		.cmd      (push_cmd)
	);

	uee_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.full       (q_full)
	);

	uee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.capacity   (capacity_q),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.is_end     (is_end),
		.overflow   (overflow),
		.out_length (out_length)
	);

endmodule

[rtl/uee_front.sv]
// Front part: accepts input words, tracks escape and character state, builds commands.
`timescale 1ns / 1ps

module uee_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          eol_care,
	input  logic          q_full,
	output logic          push,
	output uee_pkg::cmd_t cmd
);

	// Parser phase codes.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_ESC    = 3'd1;
	localparam logic [2:0] PH_XSEEN  = 3'd2;
	localparam logic [2:0] PH_XDIGIT = 3'd3;
	localparam logic [2:0] PH_CONT   = 3'd4;

	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_LX  = 8'h78;
	localparam logic [7:0] CH_UX  = 8'h58;
	localparam logic [7:0] CH_LN  = 8'h6E;
	localparam logic [7:0] CH_LR  = 8'h72;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	logic [2:0] phase_q, phase_d;
	logic [3:0] hex_high_q, hex_high_d;
	logic [1:0] bytes_left_q, bytes_left_d;
	logic       x_upper_q, x_upper_d;
	logic       digit_upper_q, digit_upper_d;

	logic       accept;
	logic       char_start;
	logic [2:0] clen;
	logic       is_hex;
	logic [3:0] hex_v;
	logic [7:0] x_char;
	logic [7:0] digit_char;

	// Character length from the lead byte.
	function automatic logic [2:0] char_len(input logic [7:0] b);
		logic [2:0] n;
		begin
			if (b >= 8'hF0)      n = 3'd4;
			else if (b >= 8'hE0) n = 3'd3;
			else if (b >= 8'hC0) n = 3'd2;
			else                 n = 3'd1;
			return n;
		end
	endfunction

	// Hex digit decode, either case.
	always_comb begin
		is_hex = 1'b1;
		hex_v  = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_v = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_v = 4'(in_byte - 8'h37);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_v = 4'(in_byte - 8'h57);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign clen       = char_len(in_byte);
	assign x_char     = x_upper_q ? CH_UX : CH_LX;
	assign digit_char = (hex_high_q < 4'd10) ? (8'h30 + {4'd0, hex_high_q}) :
		((digit_upper_q ? 8'h41 : 8'h61) + {4'd0, hex_high_q} - 8'd10);

	// Build the command for this word and the next parser state.
	always_comb begin
		cmd           = '0;
		char_start    = 1'b0;
		phase_d       = PH_IDLE;
		hex_high_d    = hex_high_q;
		bytes_left_d  = bytes_left_q;
		x_upper_d     = x_upper_q;
		digit_upper_d = digit_upper_q;

		unique case (phase_q)
			PH_CONT: begin
				cmd.bytes[0] = in_byte;
				cmd.num      = 3'd1;
				if (bytes_left_q > 2'd1 && !in_last) begin
					bytes_left_d = bytes_left_q - 2'd1;
					phase_d      = PH_CONT;
				end else begin
					bytes_left_d = 2'd0;
				end
			end
			PH_ESC: begin
				if (in_byte == CH_LX || in_byte == CH_UX) begin
					x_upper_d = (in_byte == CH_UX);
					if (in_last) begin
						cmd.bytes[0] = CH_BSL;
						cmd.bytes[1] = in_byte;
						cmd.num      = 3'd2;
					end else begin
						phase_d = PH_XSEEN;
					end
				end else if (in_byte == CH_LN) begin
					cmd.bytes[0] = CH_LF;
					cmd.num      = 3'd1;
				end else if (in_byte == CH_LR) begin
					cmd.bytes[0] = CH_CR;
					cmd.num      = 3'd1;
				end else begin
					cmd.bytes[0] = in_byte;
					cmd.num      = 3'd1;
					char_start   = 1'b1;
				end
			end
			PH_XSEEN: begin
				if (is_hex && !in_last) begin
					hex_high_d    = hex_v;
					digit_upper_d = (in_byte >= 8'h41 && in_byte <= 8'h46);
					phase_d       = PH_XDIGIT;
				end else begin
					cmd.bytes[0] = CH_BSL;
					cmd.bytes[1] = x_char;
					cmd.bytes[2] = in_byte;
					cmd.num      = 3'd3;
					char_start   = 1'b1;
				end
			end
			PH_XDIGIT: begin
				if (is_hex) begin
					cmd.bytes[0] = {hex_high_q, hex_v};
					cmd.num      = 3'd1;
				end else begin
					cmd.bytes[0] = CH_BSL;
					cmd.bytes[1] = x_char;
					cmd.bytes[2] = digit_char;
					cmd.bytes[3] = in_byte;
					cmd.num      = 3'd4;
					char_start   = 1'b1;
				end
			end
			PH_IDLE: begin
				if (in_byte == CH_BSL && !in_last) begin
					phase_d = PH_ESC;
				end else if (!(eol_care && in_byte == CH_CR && in_last)) begin
					cmd.bytes[0] = in_byte;
					cmd.num      = 3'd1;
					char_start   = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// A multi-byte character arms pass-through of its continuation bytes.
		if (char_start && clen > 3'd1 && !in_last) begin
			bytes_left_d = 2'(clen - 3'd1);
			phase_d      = PH_CONT;
		end

		// End of string: optional LF, closing word, and state back to reset.
		if (in_last) begin
			if (eol_care) begin
				cmd.bytes[cmd.num] = CH_LF;
				cmd.num            = cmd.num + 3'd1;
			end
			cmd.last      = 1'b1;
			phase_d       = PH_IDLE;
			hex_high_d    = 4'd0;
			bytes_left_d  = 2'd0;
			x_upper_d     = 1'b0;
			digit_upper_d = 1'b0;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (cmd.num != 3'd0 || cmd.last);

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			hex_high_q    <= 4'd0;
			bytes_left_q  <= 2'd0;
			x_upper_q     <= 1'b0;
			digit_upper_q <= 1'b0;
		end else if (accept) begin
			phase_q       <= phase_d;
			hex_high_q    <= hex_high_d;
			bytes_left_q  <= bytes_left_d;
			x_upper_q     <= x_upper_d;
			digit_upper_q <= digit_upper_d;
		end
	end

endmodule

[rtl/uee_queue.sv]
// Command queue between the front and the back parts.
`timescale 1ns / 1ps

module uee_queue #(
	parameter int DEPTH = uee_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  uee_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          head_valid,
	output uee_pkg::cmd_t head_cmd,
	output logic          full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	uee_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_FULL);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/uee_back.sv]
// Back part: plays out each command one word a cycle while out_ready is high, and keeps the length count.
`timescale 1ns / 1ps

module uee_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   capacity,
	input  logic          head_valid,
	input  uee_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          is_end,
	output logic          overflow,
	output logic [15:0]   out_length
);

	logic [2:0]  idx_q;
	logic [15:0] count_q;
	logic        full_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        is_end_q;
	logic        overflow_q;
	logic [15:0] out_length_q;

	logic        load;
	logic        cur_is_byte;
	logic        cmd_done;
	logic [15:0] count_inc;
	logic [7:0]  cur_byte;

	assign load        = head_valid && (!out_valid_q || out_ready);
	assign cur_is_byte = (idx_q < head_cmd.num);
	assign cur_byte    = cur_is_byte ? head_cmd.bytes[idx_q] : 8'd0;
	assign count_inc   = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
	assign cmd_done    = cur_is_byte ?
		((idx_q + 3'd1 == head_cmd.num) && !head_cmd.last) : 1'b1;
	assign pop         = load && cmd_done;

	// Position within the command and the running length of the string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			count_q     <= 16'd0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= cmd_done ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
				if (cur_is_byte) begin
					count_q <= count_inc;
					full_q  <= full_q || (count_inc >= capacity);
				end else begin
					count_q <= 16'd0;
					full_q  <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (load) begin
			if (cur_is_byte) begin
				out_byte_q   <= cur_byte;
				is_end_q     <= 1'b0;
				overflow_q   <= 1'b0;
				out_length_q <= 16'd0;
			end else begin
				out_byte_q   <= 8'd0;
				is_end_q     <= 1'b1;
				overflow_q   <= full_q || (count_q >= capacity);
				out_length_q <= count_q;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_end     = is_end_q;
	assign overflow   = overflow_q;
	assign out_length = out_length_q;

endmodule

[sim/uee_checker.sv]
// Checker for the UTF-8 escape expander: predicts every output word and compares.
`timescale 1ns / 1ps

module uee_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        is_end,
	input  logic        overflow,
	input  logic [15:0] out_length,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);

	// Characters that steer the escape parser.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [4:0] NO_DIGIT  = 5'h10;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESC,
		PH_XSEEN,
		PH_XDIGIT,
		PH_CONT
	} scan_phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        closing;
		logic        ovf;
		logic [15:0] len;
	} out_word_t;

	// Predicted configuration and string state.
	logic [15:0] capacity;
	logic        eol_care;
	scan_phase_t phase;
	logic [3:0]  hex_high;
	logic [1:0]  bytes_left;
	logic [15:0] out_count;
	logic        full_flag;
	logic        x_upper;
	logic        digit_upper;

	out_word_t   expected_words[$];
	out_word_t   want;
	int          mismatches;
	int          seen;

	function automatic logic [2:0] char_span(input logic [7:0] b);
		if (b >= 8'hF0)
			return 3'd4;
		if (b >= 8'hE0)
			return 3'd3;
		if (b >= 8'hC0)
			return 3'd2;
		return 3'd1;
	endfunction

	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39)
			return 5'(b - 8'h30);
		if (b >= 8'h41 && b <= 8'h46)
			return 5'(b - 8'h41 + 8'd10);
		if (b >= 8'h61 && b <= 8'h66)
			return 5'(b - 8'h61 + 8'd10);
		return NO_DIGIT;
	endfunction

	// One expanded byte: queue it and track the running length against capacity.
	task automatic put_byte(input logic [7:0] b);
		out_word_t w;
		w = '{data: b, closing: 1'b0, ovf: 1'b0, len: 16'd0};
		expected_words.push_back(w);
		if (out_count != 16'hFFFF)
			out_count = out_count + 16'd1;
		if (out_count >= capacity)
			full_flag = 1'b1;
	endtask

	// Lead byte of a character; longer characters pass their tail bytes through.
	task automatic put_char_start(input logic [7:0] b, input logic last);
		logic [2:0] n;
		n = char_span(b);
		put_byte(b);
		if (n > 3'd1 && !last) begin
			bytes_left = 2'(n - 3'd1);
			phase = PH_CONT;
		end
	endtask

	task automatic put_x_prefix();
		put_byte(CH_BSLASH);
		put_byte(x_upper ? CH_UP_X : CH_LOW_X);
	endtask

	// Advance the predicted parser by one input word and queue what it gives.
	task automatic expand_byte(input logic [7:0] b, input logic last);
		scan_phase_t cur;
		logic [4:0]  d;
		out_word_t   w;
		cur = phase;
		phase = PH_IDLE;
		case (cur)
			PH_CONT: begin
				put_byte(b);
				if (bytes_left > 2'd1 && !last) begin
					bytes_left = bytes_left - 2'd1;
					phase = PH_CONT;
				end else begin
					bytes_left = 2'd0;
				end
			end
			PH_ESC: begin
				if (b == CH_LOW_X || b == CH_UP_X) begin
					x_upper = (b == CH_UP_X);
					if (last)
						put_x_prefix();
					else
						phase = PH_XSEEN;
				end else if (b == CH_LOW_N) begin
					put_byte(CH_LF);
				end else if (b == CH_LOW_R) begin
					put_byte(CH_CR);
				end else begin
					put_char_start(b, last);
				end
			end
			PH_XSEEN: begin
				d = hex_digit(b);
				if (d != NO_DIGIT && !last) begin
					hex_high = d[3:0];
					digit_upper = (b >= 8'h41 && b <= 8'h46);
					phase = PH_XDIGIT;
				end else begin
					put_x_prefix();
					put_char_start(b, last);
				end
			end
			PH_XDIGIT: begin
				d = hex_digit(b);
				if (d != NO_DIGIT) begin
					put_byte({hex_high, d[3:0]});
				end else begin
					// Broken escape: copy backslash, x and the first digit as written.
					put_x_prefix();
					if (hex_high < 4'd10)
						put_byte(8'h30 + 8'(hex_high));
					else
						put_byte((digit_upper ? 8'h41 : 8'h61) + 8'(hex_high) - 8'd10);
					put_char_start(b, last);
				end
			end
			default: begin
				if (b == CH_BSLASH && !last) begin
					phase = PH_ESC;
				end else if (eol_care && b == CH_CR && last) begin
					// A plain CR that ends the string is dropped.
				end else begin
					put_char_start(b, last);
				end
			end
		endcase

		// Close the string: optional LF, then the length word, then clear.
		if (last) begin
			if (eol_care)
				put_byte(CH_LF);
			if (out_count >= capacity)
				full_flag = 1'b1;
			w = '{data: 8'h00, closing: 1'b1, ovf: full_flag, len: out_count};
			expected_words.push_back(w);
			phase = PH_IDLE;
			hex_high = 4'd0;
			bytes_left = 2'd0;
			out_count = 16'd0;
			full_flag = 1'b0;
			x_upper = 1'b0;
			digit_upper = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		mismatches++;
		$display("%0t: %s mismatch on result word %0d: got %0h, expected %0h",
			$time, what, seen, got, exp_val);
	endtask

	// Track register writes, compare accepted output words, predict new ones.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity = uee_pkg::CAPACITY_RESET;
			eol_care = uee_pkg::EOL_CARE_RESET;
			phase = PH_IDLE;
			hex_high = 4'd0;
			bytes_left = 2'd0;
			out_count = 16'd0;
			full_flag = 1'b0;
			x_upper = 1'b0;
			digit_upper = 1'b0;
			expected_words.delete();
			mismatches = 0;
			seen = 0;
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					uee_pkg::REG_CAPACITY: capacity = cfg_data;
					uee_pkg::REG_EOL_CARE: eol_care = cfg_data[0];
				endcase
			end

			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", int'({is_end, out_byte}), 0);
				end else begin
					want = expected_words.pop_front();
					if (out_byte !== want.data)
						report_mismatch("out_byte", int'(out_byte), int'(want.data));
					if (is_end !== want.closing)
						report_mismatch("is_end", int'(is_end), int'(want.closing));
					if (overflow !== want.ovf)
						report_mismatch("overflow", int'(overflow), int'(want.ovf));
					if (out_length !== want.len)
						report_mismatch("out_length", int'(out_length), int'(want.len));
				end
				seen++;
			end

			if (in_valid && in_ready)
				expand_byte(in_byte, in_last);

			fail_count <= mismatches;
			pending <= expected_words.size();
			results_seen <= seen;
		end
	end

endmodule

[sim/tb.sv]
// Testbench top for the UTF-8 escape expander: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 12;
	localparam int HOLD_AT       = 120;
	localparam int LONG_HOLD     = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_WORDS   = 38;
	localparam int NUM_PHASES    = 7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        is_end;
	logic        overflow;
	logic [15:0] out_length;

	int          fail_count;
	int          pending;
	int          results_seen;
	int          words_sent = 0;
	int          strings_sent = 0;
	int          settings_applied = 0;
	int          tx_calm = 0;
	int          idle_cycles = 0;
	logic [7:0]  text_q[$];

	logic [15:0] phase_caps[NUM_PHASES] =
		'{16'd3, 16'd65535, 16'd1, 16'd20, 16'd0, 16'd8, 16'd256};
	logic        phase_eols[NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

	utf8_escape_expander dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.is_end    (is_end),
		.overflow  (overflow),
		.out_length(out_length)
	);

	uee_checker expander_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.is_end      (is_end),
		.overflow    (overflow),
		.out_length  (out_length),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	// Offer one word, with an optional idle gap first, and wait until it is taken.
	task automatic send_word(input logic [7:0] b, input logic last);
		int gap;
		int r;
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				gap = 0;
			end else if (r < 92) begin
				gap = pick_gap();
			end else begin
				gap = 0;
				tx_calm = $urandom_range(30, 80);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (!in_ready);
		words_sent <= words_sent + 1;
	endtask

	task automatic send_text();
		int k;
		for (k = 0; k < text_q.size(); k++)
			send_word(text_q[k], k == text_q.size() - 1);
		strings_sent++;
	endtask

	// Wait for the block to drain, then write both registers.
	task automatic apply_setting(input logic [15:0] cap, input logic eol);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= uee_pkg::REG_CAPACITY;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= uee_pkg::REG_EOL_CARE;
		cfg_data <= {15'd0, eol};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// A character with the tail bytes its lead byte asks for.
	task automatic push_char(input logic [7:0] lead);
		int n;
		logic [7:0] c;
		n = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : (lead >= 8'hC0) ? 1 : 0;
		text_q.push_back(lead);
		repeat (n) begin
			c = 8'($urandom_range(8'h80, 8'hBF));
			text_q.push_back(c);
		end
	endtask

	// Random string: mostly well-formed escapes and characters, some noise,
	// sometimes a trailing CR, sometimes cut short at a random byte.
	task automatic build_text();
		int tokens;
		int t;
		int r;
		int keep;
		logic [7:0] c;
		logic [3:0] v;
		text_q.delete();
		tokens = $urandom_range(1, 10);
		for (t = 0; t < tokens; t++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				c = 8'($urandom_range(8'h20, 8'h7E));
				text_q.push_back(c);
			end else if (r < 40) begin
				text_q.push_back(CH_BSLASH);
				text_q.push_back($urandom_range(0, 1) ? CH_LOW_N : CH_LOW_R);
			end else if (r < 48) begin
				text_q.push_back(CH_BSLASH);
				c = 8'($urandom_range(0, 255));
				push_char(c);
			end else if (r < 60) begin
				text_q.push_back(CH_BSLASH);
				text_q.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
				v = 4'($urandom_range(0, 15));
				text_q.push_back(hex_char(v, 1'($urandom_range(0, 1))));
				v = 4'($urandom_range(0, 15));
				text_q.push_back(hex_char(v, 1'($urandom_range(0, 1))));
			end else if (r < 66) begin
				// Broken hex escape, after the x or after one digit.
				text_q.push_back(CH_BSLASH);
				text_q.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
				if ($urandom_range(0, 1)) begin
					v = 4'($urandom_range(0, 15));
					text_q.push_back(hex_char(v, 1'($urandom_range(0, 1))));
				end
				if ($urandom_range(0, 3) == 0) begin
					c = 8'($urandom_range(8'hC0, 8'hFF));
					push_char(c);
				end else begin
					c = 8'($urandom_range(8'h67, 8'h7A));
					text_q.push_back(c);
				end
			end else if (r < 78) begin
				case ($urandom_range(2, 4))
					2: c = 8'($urandom_range(8'hC0, 8'hDF));
					3: c = 8'($urandom_range(8'hE0, 8'hEF));
					default: c = 8'($urandom_range(8'hF0, 8'hFF));
				endcase
				push_char(c);
			end else if (r < 85) begin
				text_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
			end else if (r < 90) begin
				c = 8'($urandom_range(8'h80, 8'hBF));
				text_q.push_back(c);
			end else begin
				c = 8'($urandom_range(0, 255));
				text_q.push_back(c);
			end
		end
		if ($urandom_range(0, 5) == 0)
			text_q.push_back(CH_CR);
		if (text_q.size() > 1 && $urandom_range(0, 7) == 0) begin
			keep = $urandom_range(1, text_q.size() - 1);
			while (text_q.size() > keep)
				void'(text_q.pop_back());
		end
	endtask

	// Receiver side: random ready pattern plus one long hold to back up the input.
	initial begin : receiver
		int busy_run;
		int idle_run;
		logic held;
		busy_run = 0;
		idle_run = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_sent >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (busy_run > 0) begin
				out_ready <= 1'b1;
				busy_run--;
			end else if (idle_run > 0) begin
				out_ready <= 1'b0;
				idle_run--;
			end else begin
				out_ready <= 1'b1;
				busy_run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 6);
				idle_run = pick_gap();
			end
		end
	end

	// Watchdog: too long without any word moving on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Main stimulus: directed strings, then random strings under several settings.
	initial begin : stimulus
		int p;
		int phase_words;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_setting(uee_pkg::CAPACITY_RESET, 1'b0);
		// \n \r \XaF, \x broken right after x, \xb broken after a digit, lone 0x80.
		text_q = '{8'h5C, 8'h6E, 8'h5C, 8'h72, 8'h5C, 8'h58, 8'h61, 8'h46,
			8'h5C, 8'h78, 8'h47, 8'h5C, 8'h78, 8'h62, 8'h21, 8'h80};
		send_text();
		// Four-byte lead that is also the final byte.
		text_q = '{8'h00, 8'hFF};
		send_text();
		// Escaped three-byte character cut short after its first tail byte.
		text_q = '{8'h5C, 8'hE3, 8'h81};
		send_text();
		// Backslash as the final byte.
		text_q = '{8'h5C};
		send_text();
		// Hex escape cut by the end, after the x and after one digit.
		text_q = '{8'h5C, 8'h78};
		send_text();
		text_q = '{8'h5C, 8'h58, 8'h37};
		send_text();

		// Zero capacity with line-end care: escaped CR kept, plain final CR dropped.
		apply_setting(16'd0, 1'b1);
		text_q = '{8'h5C, 8'h72};
		send_text();
		text_q = '{8'h0D};
		send_text();

		for (p = 0; p < NUM_PHASES; p++) begin
			apply_setting(phase_caps[p], phase_eols[p]);
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				build_text();
				phase_words += text_q.size();
				send_text();
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words in %0d strings under %0d register settings;",
			words_sent, strings_sent, settings_applied);
		$display("checked %0d results; output was held off once for %0d cycles.",
			results_seen, LONG_HOLD);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
